[design/kgt_pkg.sv]
// Package: shared types and constants for the keyed grant table.
package kgt_pkg;

   // Field widths fixed by the item format
   localparam int FP_FIELD_W  = 64;
   localparam int ROLE_W      = 8;
   localparam int TS_W        = 63;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 8;

   // Item kinds carried on req_tuser
   localparam logic MODE_APPLY = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Control half of the search token that walks the cell row
   typedef struct packed {
      logic valid;
      logic mode;
      logic grant;
      logic found;
      logic appended;
   } kgt_ctl_type;

endpackage : kgt_pkg

[design/kgt_cell.sv]
// One table entry plus one stage of the search token row.
module kgt_cell #(
   parameter int FP_BITS    = 64,
   parameter int CNT_W      = 10,
   parameter int CELL_INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [CNT_W-1:0]          fill_count,
   input  kgt_pkg::kgt_ctl_type      ctl_in,
   input  logic [FP_BITS-1:0]        fp_in,
   input  logic [kgt_pkg::ROLE_W-1:0] role_in,
   input  logic [kgt_pkg::TS_W-1:0]  ts_in,
   output kgt_pkg::kgt_ctl_type      ctl_out,
   output logic [FP_BITS-1:0]        fp_out,
   output logic [kgt_pkg::ROLE_W-1:0] role_out,
   output logic [kgt_pkg::TS_W-1:0]  ts_out
);
   import kgt_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_INDEX);

   // Stored entry
   logic [FP_BITS-1:0] ent_fp_ff;
   logic [ROLE_W-1:0]  ent_role_ff;
   logic               ent_active_ff;
   logic [TS_W-1:0]    ent_time_ff;

   // Token stage
   kgt_ctl_type        tok_ctl_ff,  tok_ctl_in;
   logic [FP_BITS-1:0] tok_fp_ff;
   logic [ROLE_W-1:0]  tok_role_ff;
   logic [TS_W-1:0]    tok_ts_ff;

   logic filled;
   logic is_next;
   logic key_match;
   logic hit;
   logic append;

   assign filled    = IDX < fill_count;
   assign is_next   = IDX == fill_count;
   assign key_match = (ent_role_ff == role_in) && (ent_fp_ff == fp_in);
   assign hit       = ctl_in.valid && !ctl_in.found && filled && key_match &&
                      ((ctl_in.mode == MODE_APPLY) || ent_active_ff);
   assign append    = ctl_in.valid && !ctl_in.found && (ctl_in.mode == MODE_APPLY) &&
                      is_next;

   always_comb begin
      tok_ctl_in          = ctl_in;
      tok_ctl_in.found    = ctl_in.found | hit | append;
      tok_ctl_in.appended = ctl_in.appended | append;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ctl_ff <= '0;
      end else if (advance) begin
         tok_ctl_ff <= tok_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_fp_ff   <= fp_in;
         tok_role_ff <= role_in;
         tok_ts_ff   <= ts_in;
      end
   end

   // Update the entry on an apply hit, or claim it on append
   always_ff @(posedge clock) begin
      if (advance && append) begin
         ent_fp_ff   <= fp_in;
         ent_role_ff <= role_in;
      end
      if (advance && (append || (hit && (ctl_in.mode == MODE_APPLY)))) begin
         ent_active_ff <= ctl_in.grant;
         ent_time_ff   <= ts_in;
      end
   end

   assign ctl_out  = tok_ctl_ff;
   assign fp_out   = tok_fp_ff;
   assign role_out = tok_role_ff;
   assign ts_out   = tok_ts_ff;

endmodule : kgt_cell

[design/keyed_grant_table_top.sv]
// Top level: keyed grant table built as a row of entry cells.
// Usage
//   req_ carries one apply or query item; req_tuser is the kind (0 apply a
//   grant/revoke row, 1 query) and the key is fingerprint plus role. rsp_ returns
//   one item per request: status (1 = table full, apply refused) and role_active.
// Flow
//   An accepted item becomes a search token that steps through one entry cell per
//   cycle while the row is not held; it enters cell 0 at the accepting edge and
//   its result is registered in the output register once it leaves the last cell.
//   One item is in the row at a time; req_tready rises with rsp_tvalid, so the
//   next item is taken only after the previous result is registered.
// Reset
//   Synchronous, active high. Clear the fill count, the token row and the output
//   valid, and hold req_tready low; entry contents stay and only filled entries
//   are compared.
// Back-pressure
//   If the token reaches the end of the row while the previous result is still
//   held, hold the whole row until rsp_tready frees the output register.
module keyed_grant_table_top #(
   parameter int TABLE_DEPTH = 512,
   parameter int FP_BITS     = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata, low bit up: fingerprint[63:0], role_number[71:64],
   //   is_grant[72], timestamp[135:73]
   input  logic [kgt_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_tuser: mode[0]
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata, low bit up: status[0], role_active[1], zero pad [7:2]
   output logic [kgt_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import kgt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Field offsets inside req_tdata
   localparam int ROLE_LSB  = FP_FIELD_W;
   localparam int GRANT_BIT = ROLE_LSB + ROLE_W;
   localparam int TS_LSB    = GRANT_BIT + 1;

   kgt_ctl_type        ctl_chain  [TABLE_DEPTH+1];
   logic [FP_BITS-1:0] fp_chain   [TABLE_DEPTH+1];
   logic [ROLE_W-1:0]  role_chain [TABLE_DEPTH+1];
   logic [TS_W-1:0]    ts_chain   [TABLE_DEPTH+1];

   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic             in_flight_ff,  in_flight_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic             rsp_active_ff, rsp_active_in;

   logic             req_accept;
   logic             tok_done;
   logic             out_free;
   logic             advance;

   assign req_tready = !in_flight_ff && !reset;
   assign req_accept = req_tvalid && req_tready;

   // Token leaving the last cell, and whether the output register can take it
   assign tok_done = ctl_chain[TABLE_DEPTH].valid;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = !tok_done || out_free;

   // Build the entering token straight from the request
   assign ctl_chain[0] = '{valid: req_accept, mode: req_tuser, grant: req_tdata[GRANT_BIT],
                           found: 1'b0, appended: 1'b0};
   assign fp_chain[0]   = req_tdata[FP_BITS-1:0];
   assign role_chain[0] = req_tdata[ROLE_LSB +: ROLE_W];
   assign ts_chain[0]   = req_tdata[TS_LSB +: TS_W];

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      kgt_cell #(
         .FP_BITS    (FP_BITS),
         .CNT_W      (CNT_W),
         .CELL_INDEX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .fill_count (fill_count_ff),
         .ctl_in     (ctl_chain[k]),
         .fp_in      (fp_chain[k]),
         .role_in    (role_chain[k]),
         .ts_in      (ts_chain[k]),
         .ctl_out    (ctl_chain[k+1]),
         .fp_out     (fp_chain[k+1]),
         .role_out   (role_chain[k+1]),
         .ts_out     (ts_chain[k+1])
      );
   end

   // Retire the token into the output register; bump the fill count on append
   always_comb begin
      fill_count_in = fill_count_ff;
      in_flight_in  = in_flight_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_active_in = rsp_active_ff;
      if (req_accept) begin
         in_flight_in = 1'b1;
      end
      if (tok_done && out_free) begin
         in_flight_in  = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = (ctl_chain[TABLE_DEPTH].mode == MODE_APPLY &&
                          !ctl_chain[TABLE_DEPTH].found) ? STATUS_FULL : STATUS_OK;
         rsp_active_in = (ctl_chain[TABLE_DEPTH].mode == MODE_QUERY) &&
                         ctl_chain[TABLE_DEPTH].found;
         if (ctl_chain[TABLE_DEPTH].appended) begin
            fill_count_in = fill_count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         in_flight_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         in_flight_ff  <= in_flight_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-2){1'b0}}, rsp_active_ff, rsp_status_ff};

endmodule : keyed_grant_table_top

[design/kgt_checker.sv]
// Checker: port-level properties of the keyed grant table, bound to the top.
module kgt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kgt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import kgt_pkg::*;

   // Held result must not change while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only one item in the cell row: accept closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted during a walk");

   // A result is either an apply status or a query answer, never both set
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("table full and role active together");

   // Pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:2] == '0)
      else $error("result pad bits set");

endmodule : kgt_checker

bind keyed_grant_table_top kgt_checker u_kgt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/keyed_grant_table_top_tb.sv]
// Testbench for keyed_grant_table_top: directed rows and random traffic over a key pool.
module keyed_grant_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kgt_pkg::*;

   localparam int TABLE_DEPTH    = 512;
   localparam int FP_BITS        = 64;
   // Random items after the 24 directed rows, about 450 items in all.
   localparam int RANDOM_ITEMS   = 426;
   localparam int POOL_LIMIT     = 48;
   // Worst quiet stretch is one walk plus the result stall; allow ~8x.
   localparam int WATCHDOG_LIMIT = 4000;
   // Settle time after the last result: one full walk and some margin.
   localparam int DRAIN_CYCLES   = TABLE_DEPTH + 80;

   localparam logic [63:0] FP_MASK = {64{1'b1}} >> (64 - FP_BITS);
   localparam logic [63:0] FP_ONES = {64{1'b1}};
   localparam logic [62:0] TS_MAX  = {63{1'b1}};

   localparam logic GRANT  = 1'b1;
   localparam logic REVOKE = 1'b0;

   // How a directed row gets its expectation
   localparam logic BY_TABLE     = 1'b1;
   localparam logic BY_PREDICTOR = 1'b0;

   typedef struct packed {
      logic        mode;
      logic [63:0] fp;
      logic [7:0]  role;
      logic        grant;
      logic [62:0] ts;
   } req_item_type;

   typedef struct packed {
      logic status;
      logic active;
   } answer_type;

   typedef struct packed {
      logic [63:0] fp;
      logic [7:0]  role;
   } grant_key_type;

   typedef struct packed {
      req_item_type item;
      logic         source;
      answer_type   ans;
   } directed_row_type;

   localparam answer_type ANS_OK_IDLE = '{STATUS_OK, 1'b0};

   localparam logic [63:0] FP_FIVES = 64'h5555_5555_5555_5555;
   localparam logic [63:0] FP_TENS  = 64'hAAAA_AAAA_AAAA_AAAA;

   // Directed rows. Only answers obvious from the table contents are typed in;
   // the rest take the predictor's answer (their ans column is unused).
   directed_row_type directed_rows [24] = '{
      // empty table: nothing can be active
      '{'{MODE_QUERY, 64'h0,   8'h00, REVOKE, 63'h0},   BY_TABLE,     ANS_OK_IDLE},
      // query ignores grant and timestamp
      '{'{MODE_QUERY, FP_ONES, 8'hFF, GRANT,  TS_MAX},  BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_APPLY, 64'h0,   8'h00, GRANT,  63'h1},   BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, 64'h0,   8'h00, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      // same fingerprint, other role
      '{'{MODE_QUERY, 64'h0,   8'hFF, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      // one fingerprint bit off
      '{'{MODE_QUERY, 64'h1,   8'h00, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_APPLY, FP_ONES, 8'hFF, GRANT,  TS_MAX},  BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_ONES, 8'hFF, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_ONES, 8'h00, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_ONES >> 1, 8'hFF, GRANT, 63'h0}, BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_APPLY, FP_ONES, 8'hFF, REVOKE, 63'h5},   BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_ONES, 8'hFF, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      // revoke of an absent key appends an inactive entry; zero time stored as is
      '{'{MODE_APPLY, FP_FIVES, 8'h55, REVOKE, 63'h0},  BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_FIVES, 8'h55, GRANT,  63'h0},  BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_APPLY, FP_FIVES, 8'h55, GRANT,  63'h7},  BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_FIVES, 8'h55, REVOKE, 63'h0},  BY_PREDICTOR, ANS_OK_IDLE},
      // repeated applies: the latest one wins, even with an older time
      '{'{MODE_APPLY, FP_TENS, 8'hAA, GRANT,  63'd100}, BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_APPLY, FP_TENS, 8'hAA, REVOKE, 63'd101}, BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_TENS, 8'hAA, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_APPLY, FP_TENS, 8'hAA, GRANT,  63'd99},  BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, FP_TENS, 8'hAA, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_QUERY, 64'h0,   8'h00, GRANT,  TS_MAX},  BY_PREDICTOR, ANS_OK_IDLE},
      '{'{MODE_APPLY, 64'h0,   8'h00, REVOKE, TS_MAX},  BY_TABLE,     ANS_OK_IDLE},
      '{'{MODE_QUERY, 64'h0,   8'h00, REVOKE, 63'h0},   BY_PREDICTOR, ANS_OK_IDLE}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = MODE_APPLY;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   // Predictor's copy of the table
   logic [63:0] held_fp     [TABLE_DEPTH];
   logic [7:0]  held_role   [TABLE_DEPTH];
   logic        held_active [TABLE_DEPTH];
   logic [62:0] held_time   [TABLE_DEPTH];
   int          held_count = 0;

   answer_type    awaited_answers [$];
   grant_key_type known_keys [$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  items_sent     = 0;
   int  results_taken  = 0;
   int  n_apply        = 0;
   int  n_query        = 0;
   int  n_refused      = 0;
   int  n_found        = 0;
   bit  req_calm       = 1'b0;
   bit  rsp_calm       = 1'b0;

   always #5 clock = ~clock;

   keyed_grant_table_top #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FP_BITS     (FP_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Work out the answer to one accepted item and advance the predicted table.
   function automatic answer_type predict_grant_answer(input req_item_type it);
      answer_type  ans;
      int          hit;
      logic [63:0] fp;
      ans = ANS_OK_IDLE;
      hit = -1;
      fp  = it.fp & FP_MASK;
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_fp[i] == fp && held_role[i] == it.role) hit = i;
      end
      if (it.mode == MODE_QUERY) begin
         n_query++;
         ans.active = (hit >= 0) && held_active[hit];
         if (ans.active) n_found++;
      end else begin
         n_apply++;
         if (hit < 0) begin
            if (held_count >= TABLE_DEPTH) begin
               ans.status = STATUS_FULL;
               n_refused++;
            end else begin
               hit = held_count;
               held_count++;
               held_fp[hit]   = fp;
               held_role[hit] = it.role;
            end
         end
         if (ans.status == STATUS_OK) begin
            held_active[hit] = it.grant;
            held_time[hit]   = it.ts;
         end
      end
      return ans;
   endfunction

   // Idle draw for either side; calm stretches run without gaps.
   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   // Pick a key: fresh, reused from the pool, or a near miss of a pooled key.
   function automatic grant_key_type pick_key(input int fresh_pct);
      grant_key_type k;
      if (known_keys.size() == 0 || $urandom_range(1, 100) <= fresh_pct) begin
         case ($urandom_range(0, 7))
            0:       k.fp = 64'h0;
            1:       k.fp = FP_ONES;
            default: k.fp = {$urandom, $urandom};
         endcase
         k.role = 8'($urandom_range(0, 255));
         if (known_keys.size() < POOL_LIMIT) known_keys.push_back(k);
      end else begin
         k = known_keys[$urandom_range(0, known_keys.size() - 1)];
         if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1)) k.fp[$urandom_range(0, 63)] ^= 1'b1;
            else k.role[$urandom_range(0, 7)] ^= 1'b1;
         end
      end
      return k;
   endfunction

   function automatic req_item_type random_request(input int fresh_pct, input int apply_pct);
      req_item_type  it;
      grant_key_type k;
      k        = pick_key(fresh_pct);
      it.mode  = ($urandom_range(1, 100) <= apply_pct) ? MODE_APPLY : MODE_QUERY;
      it.fp    = k.fp;
      it.role  = k.role;
      it.grant = ($urandom_range(0, 9) < 6) ? GRANT : REVOKE;
      case ($urandom_range(0, 15))
         0:       it.ts = 63'h0;
         1:       it.ts = TS_MAX;
         default: it.ts = 63'({$urandom, $urandom});
      endcase
      return it;
   endfunction

   // Offer one item, hold it until taken, then log its expected answer.
   task automatic offer_request(input req_item_type it, input logic source,
                                input answer_type typed);
      int         gap;
      answer_type want;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {it.ts, it.grant, it.role, it.fp};
      req_tuser  <= it.mode;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      want = predict_grant_answer(it);
      awaited_answers.push_back(source == BY_TABLE ? typed : want);
      items_sent++;
      if (items_sent % 32 == 0) req_calm = ($urandom_range(0, 3) == 0);
   endtask

   // Result side: once a result shows, stall it for the drawn number of cycles.
   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         results_taken++;
         if (results_taken % 24 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // Compare every taken result with the oldest expectation, field by field.
   always @(posedge clock) begin : check_results
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: result with nothing expected: status %0b role_active %0b",
                     $time, rsp_tdata[0], rsp_tdata[1]);
            mismatch_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_tdata[0] !== want.status) begin
               $display("%0t: status mismatch: expected %0b, actual %0b",
                        $time, want.status, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1] !== want.active) begin
               $display("%0t: role_active mismatch: expected %0b, actual %0b",
                        $time, want.active, rsp_tdata[1]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: drop the run once no handshake has happened for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still outstanding",
                  $time, awaited_answers.size());
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows first
      foreach (directed_rows[r])
         offer_request(directed_rows[r].item, directed_rows[r].source, directed_rows[r].ans);

      // Random traffic over a small key pool, so most items hit stored keys
      repeat (RANDOM_ITEMS) offer_request(random_request(15, 50), BY_PREDICTOR, ANS_OK_IDLE);
      req_tvalid <= 1'b0;

      // Hold until every result is in, then watch for strays
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d applies (%0d refused), %0d queries",
               items_sent, n_apply, n_refused, n_query);
      $display("Queries that found an active entry: %0d; entries filled: %0d of %0d",
               n_found, held_count, TABLE_DEPTH);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule : keyed_grant_table_top_tb
